>>> design/sgim_pkg.sv
// Shared types and constants for the structured grid index mapper.
// Used by design/structured_grid_index_mapper.sv and the dv benches; depends on nothing.
package sgim_pkg;

	localparam int INDEX_BITS_DEF = 32;
	localparam int ID_W           = 63;
	localparam int COORD_W        = 32;
	localparam int NUM_REGS       = 6;

	localparam logic [2:0] OP_PT_TO_ID   = 3'd0;
	localparam logic [2:0] OP_ID_TO_PT   = 3'd1;
	localparam logic [2:0] OP_CELL_TO_ID = 3'd2;
	localparam logic [2:0] OP_ID_TO_CELL = 3'd3;
	localparam logic [2:0] OP_CORNERS    = 3'd4;

	localparam logic [2:0] HEX_ORDER [8] = '{3'd0, 3'd1, 3'd3, 3'd2, 3'd4, 3'd5, 3'd7, 3'd6};
	localparam logic [1:0] QUAD_ORDER [4] = '{2'd0, 2'd1, 2'd3, 2'd2};
	localparam logic signed [63:0] EMPTY_EXTENT [NUM_REGS] = '{64'sd0, -64'sd1, 64'sd0,
		-64'sd1, 64'sd0, -64'sd1};

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_INVALID  = 2'd1,
		STS_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		GRID_OK    = 2'd0,
		GRID_EMPTY = 2'd1,
		GRID_OVER  = 2'd2
	} grid_t;

	typedef enum logic [2:0] {
		STEP_P01, STEP_NP, STEP_C01, STEP_NC, STEP_HI, STEP_MID
	} step_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_EVAL, ST_MUL, ST_MUL_DONE, ST_CHECK, ST_DIV, ST_DIV_DONE,
		ST_SUM, ST_CORNER, ST_RESP
	} state_t;

endpackage

>>> design/structured_grid_index_mapper.sv
// Structured grid index mapper: top level with sequencer, shared multiplier and divider.
// Depends on design/sgim_pkg.sv.
//
// One item at a time: in_stall is low only while the block is idle. Grid sizes are checked
// with four 64x64 products, each built from four 32x32 partial products. Point and cell
// ids add two more products; id decomposition runs two bit-serial divisions through one
// restoring divider. The corner opcode then delivers one beat per cycle while the output
// is not stalled, 1 to 8 beats, with last on the final one. Results wait in an output
// register.
module structured_grid_index_mapper #(
	parameter int INDEX_BITS = sgim_pkg::INDEX_BITS_DEF,
	parameter int DATA_W     = (INDEX_BITS > 32) ? 64 : 32,
	parameter int ADDR_W     = $clog2(sgim_pkg::NUM_REGS * (DATA_W / 8))
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [2:0]                 opcode,
	input  logic [sgim_pkg::COORD_W-1:0] idx_i,
	input  logic [sgim_pkg::COORD_W-1:0] idx_j,
	input  logic [sgim_pkg::COORD_W-1:0] idx_k,
	input  logic [sgim_pkg::ID_W-1:0]  id_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 status,
	output logic [sgim_pkg::ID_W-1:0]  id_out,
	output logic [sgim_pkg::COORD_W-1:0] out_i,
	output logic [sgim_pkg::COORD_W-1:0] out_j,
	output logic [sgim_pkg::COORD_W-1:0] out_k,
	output logic                       last,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ADDR_W-1:0]          paddr,
	input  logic [DATA_W-1:0]          pwdata,
	output logic [DATA_W-1:0]          prdata,
	output logic                       pready
);

	localparam int ID_W    = sgim_pkg::ID_W;
	localparam int COORD_W = sgim_pkg::COORD_W;
	localparam int LSB     = $clog2(DATA_W / 8);
	localparam logic [63:0] IDX_MASK = (64'd1 << INDEX_BITS) - 64'd1;
	localparam logic [5:0] DIV_LAST = 6'(ID_W - 1);

	// ---------------------------------------------------------------- config
	logic [INDEX_BITS-1:0] ext_q [sgim_pkg::NUM_REGS];
	logic [ADDR_W-LSB-1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:LSB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < sgim_pkg::NUM_REGS; r++)
				ext_q[r] <= sgim_pkg::EMPTY_EXTENT[r][INDEX_BITS-1:0];
		end else if (psel && penable && pwrite) begin
			for (int r = 0; r < sgim_pkg::NUM_REGS; r++)
				if (reg_idx == (ADDR_W-LSB)'(r))
					ext_q[r] <= pwdata[INDEX_BITS-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		for (int r = 0; r < sgim_pkg::NUM_REGS; r++)
			if (reg_idx == (ADDR_W-LSB)'(r))
				prdata = DATA_W'({{(64-INDEX_BITS){ext_q[r][INDEX_BITS-1]}}, ext_q[r]});
	end

	function automatic logic signed [63:0] sext_in(input logic [COORD_W-1:0] v);
		logic [63:0] u;
		u = {32'b0, v} & IDX_MASK;
		if (u[INDEX_BITS-1])
			u = u | ~IDX_MASK;
		return signed'(u);
	endfunction

	function automatic logic [COORD_W-1:0] idx_out(input logic [63:0] v);
		logic [63:0] u;
		u = v & IDX_MASK;
		return u[COORD_W-1:0];
	endfunction

	// ---------------------------------------------------------------- extent lanes
	logic signed [63:0] lo [3];
	logic signed [63:0] hi [3];
	logic [63:0]        dd [3];
	sgim_pkg::grid_t    gstat;

	always_comb begin
		gstat = sgim_pkg::GRID_OK;
		for (int a = 0; a < 3; a++) begin
			lo[a] = {{(64-INDEX_BITS){ext_q[2*a][INDEX_BITS-1]}}, ext_q[2*a]};
			hi[a] = {{(64-INDEX_BITS){ext_q[2*a+1][INDEX_BITS-1]}}, ext_q[2*a+1]};
			dd[a] = 64'(hi[a]) - 64'(lo[a]) + 64'd1;
		end
		// first failing axis decides
		for (int a = 2; a >= 0; a--) begin
			if (hi[a] < lo[a])
				gstat = sgim_pkg::GRID_EMPTY;
			else if (dd[a][63])
				gstat = sgim_pkg::GRID_OVER;
		end
	end

	// ---------------------------------------------------------------- item registers
	sgim_pkg::state_t   state_q, state_d;
	sgim_pkg::step_t    step_q;
	logic [2:0]         op_q;
	logic signed [63:0] ijk_q [3];
	logic [ID_W-1:0]    id_q;
	logic [63:0]        d_q [3];
	logic [63:0]        cd_q [3];
	logic [ID_W-1:0]    p01_q, c01_q, np_q, hi_q, mid_q, base_q;
	logic [ID_W-1:0]    off_q [3];
	logic               dsel_q;
	logic [2:0]         cc_q;

	logic [1:0]         res_status_q;
	logic [ID_W-1:0]    res_id_q;
	logic [COORD_W-1:0] res_i_q, res_j_q, res_k_q;

	logic out_valid_q;
	logic [1:0] status_q;
	logic [ID_W-1:0] id_out_q;
	logic [COORD_W-1:0] out_i_q, out_j_q, out_k_q;
	logic last_q;

	logic op_bad, is_cell_op, out_free;
	assign op_bad     = op_q > sgim_pkg::OP_CORNERS;
	assign is_cell_op = (op_q == sgim_pkg::OP_CELL_TO_ID);
	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != sgim_pkg::ST_IDLE);

	// ---------------------------------------------------------------- shared multiplier
	logic [2:0]   mc_q;
	logic [63:0]  pp_q;
	logic [127:0] acc_q;
	logic [63:0]  ma, mb;
	logic [31:0]  pa, pb;
	logic [6:0]   pp_sh;
	logic [ID_W-1:0] mul_res;
	logic         mul_ovf;
	logic [63:0]  l01, l0;

	assign l01 = {1'b0, is_cell_op ? c01_q : p01_q};
	assign l0  = is_cell_op ? cd_q[0] : d_q[0];

	always_comb begin
		ma = '0;
		mb = '0;
		case (step_q)
			sgim_pkg::STEP_P01: begin ma = d_q[0];         mb = d_q[1];  end
			sgim_pkg::STEP_NP:  begin ma = {1'b0, p01_q};  mb = d_q[2];  end
			sgim_pkg::STEP_C01: begin ma = cd_q[0];        mb = cd_q[1]; end
			sgim_pkg::STEP_NC:  begin ma = {1'b0, c01_q};  mb = cd_q[2]; end
			sgim_pkg::STEP_HI:  begin ma = {1'b0, off_q[2]}; mb = l01;   end
			sgim_pkg::STEP_MID: begin ma = {1'b0, off_q[1]}; mb = l0;    end
			default:            begin ma = '0;             mb = '0;      end
		endcase
		pa = mc_q[1] ? ma[63:32] : ma[31:0];
		pb = mc_q[0] ? mb[63:32] : mb[31:0];
		// shift for the partial product produced in the previous cycle
		case (mc_q)
			3'd1:    pp_sh = 7'd0;
			3'd2:    pp_sh = 7'd32;
			3'd3:    pp_sh = 7'd32;
			3'd4:    pp_sh = 7'd64;
			default: pp_sh = 7'd0;
		endcase
	end

	assign mul_res = acc_q[ID_W-1:0];
	assign mul_ovf = |acc_q[127:ID_W];

	// ---------------------------------------------------------------- shared divider
	logic [5:0]      dc_q;
	logic [ID_W-1:0] dvd_q, quo_q, rem_q;
	logic [63:0]     dvs_q;
	logic [63:0]     trial;
	logic            take;

	assign trial = {rem_q, dvd_q[ID_W-1]};
	assign take  = (trial >= dvs_q);

	// ---------------------------------------------------------------- checks and corners
	logic        chk_fail;
	logic [63:0] offc [3];
	logic [2:0]  act;
	logic [1:0]  nact;
	logic [2:0]  code, amask, cmax;
	logic        corner_last;
	logic [ID_W-1:0] corner_id;

	always_comb begin
		chk_fail = 1'b0;
		for (int a = 0; a < 3; a++) begin
			offc[a] = 64'(ijk_q[a]) - 64'(lo[a]);
			if (ijk_q[a] < lo[a])
				chk_fail = 1'b1;
			else if (offc[a] >= ((op_q == sgim_pkg::OP_PT_TO_ID) ? d_q[a] : cd_q[a]))
				chk_fail = 1'b1;
		end
	end

	always_comb begin
		logic [1:0] j;
		j = '0;
		for (int a = 0; a < 3; a++)
			act[a] = (d_q[a] > 64'd1);
		nact = 2'(act[0]) + 2'(act[1]) + 2'(act[2]);
		if (nact == 2'd2)
			code = {1'b0, sgim_pkg::QUAD_ORDER[cc_q[1:0]]};
		else if (nact == 2'd3)
			code = sgim_pkg::HEX_ORDER[cc_q];
		else
			code = cc_q;
		amask = '0;
		for (int a = 0; a < 3; a++) begin
			if (act[a]) begin
				amask[a] = code[j];
				j = j + 2'd1;
			end
		end
		cmax = {nact == 2'd3, nact >= 2'd2, nact >= 2'd1};
		corner_last = (cc_q == cmax);
		corner_id = base_q + ID_W'(amask[0]) + (amask[1] ? d_q[0][ID_W-1:0] : '0)
			+ (amask[2] ? p01_q : '0);
	end

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= sgim_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sgim_pkg::ST_IDLE:
				if (in_valid) state_d = sgim_pkg::ST_EVAL;
			sgim_pkg::ST_EVAL:
				if (op_bad || gstat != sgim_pkg::GRID_OK) state_d = sgim_pkg::ST_RESP;
				else state_d = sgim_pkg::ST_MUL;
			sgim_pkg::ST_MUL:
				if (mc_q == 3'd4) state_d = sgim_pkg::ST_MUL_DONE;
			sgim_pkg::ST_MUL_DONE: begin
				case (step_q)
					sgim_pkg::STEP_HI: state_d = sgim_pkg::ST_MUL;
					sgim_pkg::STEP_MID: state_d = sgim_pkg::ST_SUM;
					sgim_pkg::STEP_NC: begin
						if (mul_ovf)
							state_d = sgim_pkg::ST_RESP;
						else if (op_q == sgim_pkg::OP_PT_TO_ID || is_cell_op)
							state_d = sgim_pkg::ST_CHECK;
						else if (op_q == sgim_pkg::OP_ID_TO_PT)
							state_d = (id_q >= np_q) ? sgim_pkg::ST_RESP : sgim_pkg::ST_DIV;
						else
							state_d = (id_q >= mul_res) ? sgim_pkg::ST_RESP : sgim_pkg::ST_DIV;
					end
					default:
						state_d = mul_ovf ? sgim_pkg::ST_RESP : sgim_pkg::ST_MUL;
				endcase
			end
			sgim_pkg::ST_CHECK:
				state_d = chk_fail ? sgim_pkg::ST_RESP : sgim_pkg::ST_MUL;
			sgim_pkg::ST_DIV:
				if (dc_q == DIV_LAST) state_d = sgim_pkg::ST_DIV_DONE;
			sgim_pkg::ST_DIV_DONE:
				if (!dsel_q) state_d = sgim_pkg::ST_DIV;
				else if (op_q == sgim_pkg::OP_CORNERS) state_d = sgim_pkg::ST_MUL;
				else state_d = sgim_pkg::ST_RESP;
			sgim_pkg::ST_SUM:
				state_d = (op_q == sgim_pkg::OP_CORNERS) ? sgim_pkg::ST_CORNER
					: sgim_pkg::ST_RESP;
			sgim_pkg::ST_CORNER:
				if (out_free && corner_last) state_d = sgim_pkg::ST_IDLE;
			sgim_pkg::ST_RESP:
				if (out_free) state_d = sgim_pkg::ST_IDLE;
			default:
				state_d = sgim_pkg::ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mc_q   <= '0;
			dc_q   <= '0;
			cc_q   <= '0;
			dsel_q <= 1'b0;
			step_q <= sgim_pkg::STEP_P01;
		end else begin
			mc_q <= (state_q == sgim_pkg::ST_MUL) ? mc_q + 3'd1 : 3'd0;
			case (state_q)
				sgim_pkg::ST_IDLE:
					if (in_valid) begin
						op_q     <= opcode;
						ijk_q[0] <= sext_in(idx_i);
						ijk_q[1] <= sext_in(idx_j);
						ijk_q[2] <= sext_in(idx_k);
						id_q     <= id_in;
					end
				sgim_pkg::ST_EVAL: begin
					for (int a = 0; a < 3; a++) begin
						d_q[a]  <= dd[a];
						cd_q[a] <= (dd[a] > 64'd1) ? dd[a] - 64'd1 : 64'd1;
					end
					step_q <= sgim_pkg::STEP_P01;
					cc_q   <= '0;
					dsel_q <= 1'b0;
					res_status_q <= (!op_bad && gstat == sgim_pkg::GRID_OVER)
						? sgim_pkg::STS_OVERFLOW : sgim_pkg::STS_INVALID;
					res_id_q <= '0;
					res_i_q  <= '0;
					res_j_q  <= '0;
					res_k_q  <= '0;
				end
				sgim_pkg::ST_MUL: begin
					if (mc_q < 3'd4)
						pp_q <= pa * pb;
					if (mc_q == 3'd0)
						acc_q <= '0;
					else
						acc_q <= acc_q + ({64'b0, pp_q} << pp_sh);
				end
				sgim_pkg::ST_MUL_DONE: begin
					res_status_q <= mul_ovf ? sgim_pkg::STS_OVERFLOW : sgim_pkg::STS_INVALID;
					case (step_q)
						sgim_pkg::STEP_P01: begin p01_q <= mul_res; step_q <= sgim_pkg::STEP_NP; end
						sgim_pkg::STEP_NP:  begin np_q <= mul_res;  step_q <= sgim_pkg::STEP_C01; end
						sgim_pkg::STEP_C01: begin c01_q <= mul_res; step_q <= sgim_pkg::STEP_NC; end
						sgim_pkg::STEP_NC: begin
							// first division: id over the plane size
							dvd_q <= id_q;
							rem_q <= '0;
							dvs_q <= (op_q == sgim_pkg::OP_ID_TO_PT) ? {1'b0, p01_q}
								: {1'b0, c01_q};
							dc_q  <= '0;
						end
						sgim_pkg::STEP_HI: begin hi_q <= mul_res; step_q <= sgim_pkg::STEP_MID; end
						sgim_pkg::STEP_MID: mid_q <= mul_res;
						default: ;
					endcase
				end
				sgim_pkg::ST_CHECK: begin
					for (int a = 0; a < 3; a++)
						off_q[a] <= offc[a][ID_W-1:0];
					step_q <= sgim_pkg::STEP_HI;
				end
				sgim_pkg::ST_DIV: begin
					dvd_q <= {dvd_q[ID_W-2:0], 1'b0};
					quo_q <= {quo_q[ID_W-2:0], take};
					rem_q <= take ? ID_W'(trial - dvs_q) : trial[ID_W-1:0];
					dc_q  <= dc_q + 6'd1;
				end
				sgim_pkg::ST_DIV_DONE: begin
					dc_q <= '0;
					if (!dsel_q) begin
						off_q[2] <= quo_q;
						dvd_q    <= rem_q;
						rem_q    <= '0;
						dvs_q    <= (op_q == sgim_pkg::OP_ID_TO_PT) ? d_q[0] : cd_q[0];
						dsel_q   <= 1'b1;
					end else begin
						off_q[1] <= quo_q;
						off_q[0] <= rem_q;
						step_q   <= sgim_pkg::STEP_HI;
						res_status_q <= sgim_pkg::STS_OK;
						res_i_q <= idx_out(64'(lo[0]) + {1'b0, rem_q});
						res_j_q <= idx_out(64'(lo[1]) + {1'b0, quo_q});
						res_k_q <= idx_out(64'(lo[2]) + {1'b0, off_q[2]});
					end
				end
				sgim_pkg::ST_SUM: begin
					base_q       <= hi_q + mid_q + off_q[0];
					res_id_q     <= hi_q + mid_q + off_q[0];
					res_status_q <= sgim_pkg::STS_OK;
				end
				sgim_pkg::ST_CORNER:
					if (out_free) cc_q <= cc_q + 3'd1;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free && state_q == sgim_pkg::ST_CORNER) begin
			out_valid_q <= 1'b1;
			status_q    <= sgim_pkg::STS_OK;
			id_out_q    <= corner_id;
			out_i_q     <= '0;
			out_j_q     <= '0;
			out_k_q     <= '0;
			last_q      <= corner_last;
		end else if (out_free && state_q == sgim_pkg::ST_RESP) begin
			out_valid_q <= 1'b1;
			status_q    <= res_status_q;
			id_out_q    <= res_id_q;
			out_i_q     <= res_i_q;
			out_j_q     <= res_j_q;
			out_k_q     <= res_k_q;
			last_q      <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign id_out    = id_out_q;
	assign out_i     = out_i_q;
	assign out_j     = out_j_q;
	assign out_k     = out_k_q;
	assign last      = last_q;

	// ---------------------------------------------------------------- assertions
	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == sgim_pkg::ST_EVAL)
		else $error("accepted beat did not start evaluation");

	a_corner_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sgim_pkg::ST_CORNER |-> (cc_q & ~cmax) == 3'd0)
		else $error("corner counter beyond corner count");

	a_last_only_corners: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> op_q == sgim_pkg::OP_CORNERS)
		else $error("non-final beat outside corner opcode");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sgim_pkg::ST_DIV |-> dc_q <= DIV_LAST)
		else $error("divider ran past its last step");

endmodule

>>> dv/grid_index_checker.sv
`timescale 1ns / 1ps
// Checker for the structured grid index mapper: tracks register writes,
// predicts result beats per accepted request and compares them in order.
// Depends on sgim_pkg for opcodes and status codes.
module grid_index_checker #(
	parameter int ADDR_W = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [2:0]        opcode,
	input  logic [31:0]       idx_i,
	input  logic [31:0]       idx_j,
	input  logic [31:0]       idx_k,
	input  logic [62:0]       id_in,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [1:0]        status,
	input  logic [62:0]       id_out,
	input  logic [31:0]       out_i,
	input  logic [31:0]       out_j,
	input  logic [31:0]       out_k,
	input  logic              last,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output int                errors,
	output int                pending
);
	import sgim_pkg::*;

	localparam logic [63:0] ID_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef struct {
		status_t     sts;
		logic [62:0] id;
		logic [31:0] i;
		logic [31:0] j;
		logic [31:0] k;
		logic        lst;
	} grid_beat_t;

	grid_beat_t  beats_due[$];
	longint      bounds[NUM_REGS];

	assign pending = beats_due.size();

	function automatic bit prod_fits(input logic [63:0] a, input logic [63:0] b,
		output logic [63:0] r);
		r = a * b;
		return !(a != 0 && b > ID_MAX / a);
	endfunction

	function automatic void push_beat(input status_t s, input logic [63:0] id,
		input logic [63:0] i, input logic [63:0] j, input logic [63:0] k, input bit l);
		grid_beat_t b;
		b.sts = s;
		b.id  = id[62:0];
		b.i   = i[31:0];
		b.j   = j[31:0];
		b.k   = k[31:0];
		b.lst = l;
		beats_due.push_back(b);
	endfunction

	function automatic void predict_map(input logic [2:0] op, input longint ix[3],
		input logic [63:0] id);
		logic [63:0] dim[3], cdim[3], lim[3], off[3], pcount, ccount, q, r, cnt, p[3];
		int          grid;
		int          act[3];
		int          nact;
		logic [2:0]  code;
		grid = 1;
		pcount = 0;
		ccount = 0;
		nact = 0;
		for (int a = 0; a < 3; a++) begin
			dim[a] = 0;
			cdim[a] = 1;
		end
		for (int a = 0; a < 3; a++) begin
			if (grid == 1) begin
				if (bounds[2*a+1] < bounds[2*a]) begin
					grid = 0;
				end else begin
					dim[a] = bounds[2*a+1] - bounds[2*a] + 1;
					if (dim[a] > ID_MAX) grid = 2;
					cdim[a] = dim[a] > 1 ? dim[a] - 1 : 1;
				end
			end
		end
		if (grid == 1) begin
			if (!prod_fits(dim[0], dim[1], pcount) || !prod_fits(pcount, dim[2], pcount))
				grid = 2;
			else if (!prod_fits(cdim[0], cdim[1], ccount)
				|| !prod_fits(ccount, cdim[2], ccount))
				grid = 2;
		end
		if (grid != 1) begin
			pcount = 0;
			ccount = 0;
		end
		if (op > OP_CORNERS) begin
			push_beat(STS_INVALID, 0, 0, 0, 0, 1);
			return;
		end
		if (grid == 2) begin
			push_beat(STS_OVERFLOW, 0, 0, 0, 0, 1);
			return;
		end
		if (op == OP_PT_TO_ID || op == OP_CELL_TO_ID) begin
			lim = (op == OP_PT_TO_ID) ? dim : cdim;
			if ((op == OP_PT_TO_ID ? pcount : ccount) == 0) begin
				push_beat(STS_INVALID, 0, 0, 0, 0, 1);
				return;
			end
			for (int a = 0; a < 3; a++) begin
				off[a] = ix[a] - bounds[2*a];
				if (ix[a] < bounds[2*a] || off[a] >= lim[a]) begin
					push_beat(STS_INVALID, 0, 0, 0, 0, 1);
					return;
				end
			end
			push_beat(STS_OK, off[2] * (lim[0] * lim[1]) + off[1] * lim[0] + off[0],
				0, 0, 0, 1);
			return;
		end
		if (op == OP_ID_TO_PT) begin
			if (id >= pcount) begin
				push_beat(STS_INVALID, 0, 0, 0, 0, 1);
				return;
			end
			q = id / (dim[0] * dim[1]);
			r = id % (dim[0] * dim[1]);
			push_beat(STS_OK, 0, bounds[0] + r % dim[0], bounds[2] + r / dim[0],
				bounds[4] + q, 1);
			return;
		end
		if (id >= ccount) begin
			push_beat(STS_INVALID, 0, 0, 0, 0, 1);
			return;
		end
		q = id / (cdim[0] * cdim[1]);
		r = id % (cdim[0] * cdim[1]);
		off[0] = r % cdim[0];
		off[1] = r / cdim[0];
		off[2] = q;
		if (op == OP_ID_TO_CELL) begin
			push_beat(STS_OK, 0, bounds[0] + off[0], bounds[2] + off[1],
				bounds[4] + off[2], 1);
			return;
		end
		for (int a = 0; a < 3; a++) begin
			if (dim[a] > 1) begin
				act[nact] = a;
				nact++;
			end
		end
		cnt = 64'd1 << nact;
		for (int c = 0; c < cnt; c++) begin
			code = nact == 2 ? {1'b0, QUAD_ORDER[c & 3]}
				: (nact == 3 ? HEX_ORDER[c & 7] : c[2:0]);
			p = off;
			for (int b = 0; b < nact; b++)
				if (code[b]) p[act[b]] = p[act[b]] + 1;
			push_beat(STS_OK, p[2] * (dim[0] * dim[1]) + p[1] * dim[0] + p[0],
				0, 0, 0, c + 1 == cnt);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		longint     ix[3];
		grid_beat_t exp_b;
		if (!arst_n) begin
			for (int a = 0; a < NUM_REGS; a++) bounds[a] = EMPTY_EXTENT[a];
			beats_due.delete();
			errors <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] < NUM_REGS)
				bounds[paddr[ADDR_W-1:2]] = longint'(signed'(pwdata));
			if (out_valid && !out_stall) begin
				if (beats_due.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10)
						$display("unexpected result beat: status %0d id %0h", status, id_out);
				end else begin
					exp_b = beats_due.pop_front();
					if (status !== exp_b.sts || id_out !== exp_b.id || out_i !== exp_b.i
						|| out_j !== exp_b.j || out_k !== exp_b.k || last !== exp_b.lst) begin
						errors <= errors + 1;
						if (errors < 10)
							$display({"mismatch: exp sts %0d id %0h ijk %0h %0h %0h last %0b",
								" / got sts %0d id %0h ijk %0h %0h %0h last %0b"},
								exp_b.sts, exp_b.id, exp_b.i, exp_b.j, exp_b.k, exp_b.lst,
								status, id_out, out_i, out_j, out_k, last);
					end
				end
			end
			// predict after the pop so a same-cycle beat never matches its own request
			if (in_valid && !in_stall) begin
				ix[0] = longint'(signed'(idx_i));
				ix[1] = longint'(signed'(idx_j));
				ix[2] = longint'(signed'(idx_k));
				predict_map(opcode, ix, {1'b0, id_in});
			end
		end
	end

endmodule

>>> dv/structured_grid_index_mapper_test.sv
`timescale 1ns / 1ps
// Testbench top for the structured grid index mapper: drives requests and
// register writes, and gives the verdict. Depends on sgim_pkg and grid_index_checker.
module structured_grid_index_mapper_test;
	import sgim_pkg::*;

	localparam int          ADDR_W    = 5;
	localparam int          LIMIT     = 1000000;
	localparam logic [2:0]  REG_X_MIN = 3'd0;
	localparam logic [2:0]  REG_Z_MAX = 3'd5;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  opcode = OP_PT_TO_ID;
	logic [31:0] idx_i = '0, idx_j = '0, idx_k = '0;
	logic [62:0] id_in = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [62:0] id_out;
	logic [31:0] out_i, out_j, out_k;
	logic        last;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          errors, pending, cycles = 0;
	bit          calm = 1'b0;
	longint      lo[3], hi[3];

	always #4 clk = ~clk;

	structured_grid_index_mapper i_dut (.*);

	grid_index_checker #(.ADDR_W(ADDR_W)) i_check (.*);

	always @(negedge clk) out_stall <= calm ? 1'b0 : ($urandom_range(99) < 16);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input longint val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val[31:0];
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// set the extent, hold the grid idle first
	task automatic set_grid(input longint x0, x1, y0, y1, z0, z1);
		lo = '{x0, y0, z0};
		hi = '{x1, y1, z1};
		for (logic [2:0] r = REG_X_MIN; r <= REG_Z_MAX; r++)
			write_reg(r, r[0] ? hi[r/2] : lo[r/2]);
	endtask

	task automatic send(input logic [2:0] op, input longint a, b, c, input logic [62:0] id);
		bit held;
		if (!calm && $urandom_range(99) < 16) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= op;
		idx_i <= a[31:0];
		idx_j <= b[31:0];
		idx_k <= c[31:0];
		id_in <= id;
		#1 held = in_stall;
		@(posedge clk);
		while (held) begin
			@(negedge clk);
			#1 held = in_stall;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic longint near_axis(input int a);
		if ($urandom_range(9) == 0) return longint'(signed'($urandom));
		return lo[a] - 1 + $urandom_range(hi[a] - lo[a] + 2 > 12 ? 12 : hi[a] - lo[a] + 2);
	endfunction

	task automatic random_beats(input int n);
		logic [2:0]  op;
		logic [62:0] id;
		for (int t = 0; t < n; t++) begin
			op = ($urandom_range(19) == 0) ? $urandom_range(5, 7) : $urandom_range(4);
			id = ($urandom_range(7) == 0) ? {$urandom, $urandom} : $urandom_range(300);
			send(op, near_axis(0), near_axis(1), near_axis(2), id);
		end
	endtask

	initial begin
		longint base;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		lo = '{0, 0, 0};
		hi = '{-1, -1, -1};
		random_beats(10);
		drain();

		set_grid(-2, 3, 5, 8, -1, 1);
		send(OP_PT_TO_ID, -2, 5, -1, 0);
		send(OP_PT_TO_ID, 3, 8, 1, 0);
		send(OP_PT_TO_ID, -3, 5, -1, 0);
		send(OP_PT_TO_ID, 3, 9, 1, 0);
		send(OP_PT_TO_ID, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0);
		send(OP_ID_TO_PT, 0, 0, 0, 0);
		send(OP_ID_TO_PT, 0, 0, 0, 71);
		send(OP_ID_TO_PT, 0, 0, 0, 72);
		send(OP_CELL_TO_ID, 2, 7, 0, 0);
		send(OP_CELL_TO_ID, 3, 7, 0, 0);
		send(OP_ID_TO_CELL, 0, 0, 0, 29);
		send(OP_ID_TO_CELL, 0, 0, 0, 30);
		send(OP_CORNERS, 0, 0, 0, 0);
		send(OP_CORNERS, 0, 0, 0, 29);
		send(OP_CORNERS, 0, 0, 0, 30);
		send(OP_CORNERS, 0, 0, 0, '1);
		send(3'd5, 0, 0, 0, 0);
		send(3'd7, -1, -1, -1, '1);
		random_beats(20);
		drain();

		set_grid(10, 14, -3, 0, 7, 7);
		random_beats(25);
		drain();
		set_grid(-5, -5, 100, 102, 0, 0);
		random_beats(25);
		drain();
		set_grid(-2147483648, 2147483647, -2147483648, 2147483647, -2147483648,
			2147483647);
		random_beats(15);
		drain();
		set_grid(-2147483648, 2147483647, 0, 0, 2147483647, 2147483647);
		random_beats(25);
		send(OP_ID_TO_PT, 0, 0, 0, 63'hFFFF_FFFF);
		send(OP_CORNERS, 0, 0, 0, 63'hFFFF_FFFE);
		drain();
		set_grid(4, 3, 0, 2, 0, 2);
		random_beats(15);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			calm = (ph == 3);
			for (int a = 0; a < 3; a++) begin
				base = ($urandom_range(4) == 0) ? 64'sd2147483647 - 6 : $urandom_range(2000);
				lo[a] = base - ($urandom_range(4) == 0 ? 0 : 1000);
				hi[a] = lo[a] + $urandom_range(5) - ($urandom_range(15) == 0);
			end
			set_grid(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
			random_beats(30);
			drain();
		end

		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
